/* design/mcr_pkg.sv */
package mcr_pkg;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned RadiusW = 11;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned OffXW   = 13;
  localparam int unsigned OffYW   = 12;
  localparam int unsigned ErrW    = 15;
  localparam int unsigned PixW    = 14;

  localparam logic ActStart = 1'b0;
  localparam logic ActStep  = 1'b1;

  typedef struct packed {
    logic [CoordW-1:0]       cx;
    logic [CoordW-1:0]       cy;
    logic signed [OffXW-1:0] ox;
    logic [OffYW-1:0]        oy;
    logic [ColorW-1:0]       color;
    logic                    done;
  } step_t;

endpackage

/* design/mcr_front.sv */
module mcr_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_i,
  input  logic                      action_i,
  input  logic [mcr_pkg::CoordW-1:0]  center_x_i,
  input  logic [mcr_pkg::CoordW-1:0]  center_y_i,
  input  logic [mcr_pkg::RadiusW-1:0] radius_i,
  input  logic [mcr_pkg::ColorW-1:0]  color_i,
  output logic                      step_push_o,
  output mcr_pkg::step_t            step_o
);
  import mcr_pkg::*;

  logic signed [OffXW-1:0] x_q, x_d;
  logic [OffYW-1:0]        y_q, y_d;
  logic signed [ErrW-1:0]  e_q, e_d;
  logic [CoordW-1:0]       cx_q, cx_d, cy_q, cy_d;
  logic [ColorW-1:0]       color_q, color_d;
  logic                    active_q, active_d;

  logic [OffYW-1:0]        y_inc;
  logic signed [ErrW-1:0]  e_a, e_b, e_y;
  logic signed [OffXW-1:0] x_dec, x_n;
  logic [OffYW-1:0]        y_n;
  logic                    le0, gt0, done;
  logic                    is_step;

  always_comb begin
    y_inc = y_q + 1'b1;
    le0   = e_q[ErrW-1] || (e_q == '0);
    e_y   = e_q + $signed({2'b00, y_inc, 1'b1});
    y_n   = le0 ? y_inc : y_q;
    e_a   = le0 ? e_y : e_q;
    gt0   = !e_a[ErrW-1] && (e_a != '0);
    x_dec = x_q - 1'b1;
    e_b   = e_a - $signed({x_dec[OffXW-1], x_dec, 1'b1});
    x_n   = gt0 ? x_dec : x_q;
    done  = x_n < $signed({1'b0, y_n});
  end

  assign is_step     = req_i && (action_i == ActStep) && active_q;
  assign step_push_o = is_step;

  always_comb begin
    step_o.cx    = cx_q;
    step_o.cy    = cy_q;
    step_o.ox    = x_q;
    step_o.oy    = y_q;
    step_o.color = color_q;
    step_o.done  = done;
  end

  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    e_d      = e_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    color_d  = color_q;
    active_d = active_q;
    if (req_i && (action_i == ActStart)) begin
      x_d      = $signed({2'b00, radius_i});
      y_d      = '0;
      e_d      = '0;
      cx_d     = center_x_i;
      cy_d     = center_y_i;
      color_d  = color_i;
      active_d = 1'b1;
    end else if (is_step) begin
      x_d = x_n;
      y_d = y_n;
      e_d = gt0 ? e_b : e_a;
      if (done) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      e_q      <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      color_q  <= '0;
      active_q <= 1'b0;
    end else begin
      x_q      <= x_d;
      y_q      <= y_d;
      e_q      <= e_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      color_q  <= color_d;
      active_q <= active_d;
    end
  end

`ifndef SYNTHESIS
  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_step && done |=> !active_q)
    else $error("walk still active after final step");
  a_y_not_past_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (x_q >= $signed({1'b0, y_q})))
    else $error("active walk with x below y");
`endif

endmodule

/* design/mcr_fifo.sv */
module mcr_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mcr_pkg::step_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mcr_pkg::step_t data_o
);
  import mcr_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  step_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count overflow");
`endif

endmodule

/* design/mcr_back.sv */
module mcr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_valid_i,
  input  mcr_pkg::step_t              step_i,
  output logic                        step_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic signed [mcr_pkg::PixW-1:0] pixel_x_o,
  output logic signed [mcr_pkg::PixW-1:0] pixel_y_o,
  output logic [mcr_pkg::ColorW-1:0]  pixel_color_o,
  output logic                        last_of_step_o,
  output logic                        circle_done_o
);
  import mcr_pkg::*;

  step_t           rec_q, rec_d;
  logic            busy_q, busy_d;
  logic [2:0]      k_q, k_d;
  logic            ov_q, ov_d;
  logic [PixW-1:0] px_q, px_d, py_q, py_d;
  logic [ColorW-1:0] col_q, col_d;
  logic            last_q, last_d, done_q, done_d;

  logic            adv, take;
  logic [PixW-1:0] xs, ys, cxs, cys;

  assign adv        = busy_q && (!ov_q || pop_i);
  assign take       = step_valid_i && (!busy_q || (adv && (k_q == 3'd7)));
  assign step_pop_o = take;

  assign xs  = {rec_q.ox[OffXW-1], rec_q.ox};
  assign ys  = {2'b00, rec_q.oy};
  assign cxs = {2'b00, rec_q.cx};
  assign cys = {2'b00, rec_q.cy};

  always_comb begin
    case (k_q)
      3'd0: begin px_d = cxs + xs; py_d = cys + ys; end
      3'd1: begin px_d = cxs + ys; py_d = cys + xs; end
      3'd2: begin px_d = cxs - ys; py_d = cys + xs; end
      3'd3: begin px_d = cxs - xs; py_d = cys + ys; end
      3'd4: begin px_d = cxs - xs; py_d = cys - ys; end
      3'd5: begin px_d = cxs - ys; py_d = cys - xs; end
      3'd6: begin px_d = cxs + ys; py_d = cys - xs; end
      3'd7: begin px_d = cxs + xs; py_d = cys - ys; end
      default: begin px_d = cxs; py_d = cys; end
    endcase
    col_d  = rec_q.color;
    last_d = (k_q == 3'd7);
    done_d = (k_q == 3'd7) && rec_q.done;
  end

  always_comb begin
    rec_d  = take ? step_i : rec_q;
    k_d    = adv ? k_q + 1'b1 : k_q;
    busy_d = busy_q;
    if (adv && (k_q == 3'd7)) begin
      busy_d = 1'b0;
    end
    if (take) begin
      busy_d = 1'b1;
      k_d    = '0;
    end
    ov_d = ov_q;
    if (adv) begin
      ov_d = 1'b1;
    end else if (pop_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rec_q <= rec_d;
    end
    if (adv) begin
      px_q   <= px_d;
      py_q   <= py_d;
      col_q  <= col_d;
      last_q <= last_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
      ov_q   <= ov_d;
    end
  end

  assign empty_o        = !ov_q;
  assign pixel_x_o      = $signed(px_q);
  assign pixel_y_o      = $signed(py_q);
  assign pixel_color_o  = col_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

`ifndef SYNTHESIS
  a_rec_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (k_q != 3'd0) |-> $stable(rec_q))
    else $error("step record changed mid-step");
  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (k_q == 3'd0))
    else $error("pixel count nonzero while idle");
`endif

endmodule

/* design/midpoint_circle_rasterizer_top.sv */
// a step request yields eight pixels via the queue and step record, one per cycle while pop drains them
// the next queued step is taken as the current step's last pixel enters the single pixel output register
// start requests load the walk state and emit nothing; a short step queue decouples the two sides
// rst_ni clears the walk to idle and empties the step queue and the output register
module midpoint_circle_rasterizer_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        action_i,
  input  logic [mcr_pkg::CoordW-1:0]  center_x_i,
  input  logic [mcr_pkg::CoordW-1:0]  center_y_i,
  input  logic [mcr_pkg::RadiusW-1:0] radius_i,
  input  logic [mcr_pkg::ColorW-1:0]  color_i,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [mcr_pkg::PixW-1:0] pixel_x_o,
  output logic signed [mcr_pkg::PixW-1:0] pixel_y_o,
  output logic [mcr_pkg::ColorW-1:0]  pixel_color_o,
  output logic                        last_of_step_o,
  output logic                        circle_done_o
);
  import mcr_pkg::*;

  logic  req;
  logic  step_push, q_full, q_valid, q_pop;
  step_t step_in, step_out;

  assign full = q_full;
  assign req  = push && !q_full;

  mcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .action_i    (action_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_i    (radius_i),
    .color_i     (color_i),
    .step_push_o (step_push),
    .step_o      (step_in)
  );

  mcr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step_push),
    .data_i  (step_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (step_out)
  );

  mcr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_valid_i   (q_valid),
    .step_i         (step_out),
    .step_pop_o     (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_color_o  (pixel_color_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

`ifndef SYNTHESIS
  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && circle_done_o |-> last_of_step_o)
    else $error("circle done flagged off the last pixel of a step");
`endif

endmodule
